/* src/sme_pkg.sv */
// Package for the stack machine executor: sizes, codes, state and outcome types.
`default_nettype none
package sme_pkg;

   localparam int STACK_DEPTH = 256;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int LIMIT_W     = 9;
   localparam int DEPTH_W     = 9;
   localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int DATA_W      = 32;

   typedef enum logic [2:0] {
      CMD_HALT    = 3'd0,
      CMD_PUSH    = 3'd1,
      CMD_POP     = 3'd2,
      CMD_ADD     = 3'd3,
      CMD_SUB     = 3'd4,
      CMD_MUL     = 3'd5,
      CMD_SHOW    = 3'd6,
      CMD_UNKNOWN = 3'd7
   } cmd_type;

   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_HALTED    = 3'd1;
   localparam logic [2:0] STAT_UNDERFLOW = 3'd2;
   localparam logic [2:0] STAT_OVERFLOW  = 3'd3;
   localparam logic [2:0] STAT_UNKNOWN   = 3'd4;
   localparam logic [2:0] STAT_IGNORED   = 3'd5;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

   // outcome of one instruction, from the execute unit to the top level
   typedef struct packed {
      logic [2:0]        status;
      logic              stop;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic [CNT_W-1:0]  count;
      logic              shown_valid;
      logic [DATA_W-1:0] shown_value;
   } outcome_type;

endpackage
`default_nettype wire

/* src/sme_exec.sv */
// Execute unit: decodes one instruction against the stack state and operands.
`default_nettype none
module sme_exec (
   input  wire sme_pkg::cmd_type                 cmd,
   input  wire logic [sme_pkg::DATA_W-1:0]       immediate,
   input  wire logic [sme_pkg::CNT_W-1:0]        count,
   input  wire logic                             stopped,
   input  wire logic [sme_pkg::CMP_W-1:0]        limit,
   input  wire logic [sme_pkg::DATA_W-1:0]       op_top,
   input  wire logic [sme_pkg::DATA_W-1:0]       op_next,
   output sme_pkg::outcome_type                  outcome
);

   logic [sme_pkg::DATA_W-1:0] sum;
   logic [sme_pkg::DATA_W-1:0] diff;
   logic [sme_pkg::DATA_W-1:0] prod;
   logic [sme_pkg::CNT_W-1:0]  count_m1;
   logic [sme_pkg::CNT_W-1:0]  count_m2;

   assign sum      = op_next + op_top;
   assign diff     = op_next - op_top;
   assign prod     = op_next * op_top;   // low 32 bits, wraps
   assign count_m1 = count - sme_pkg::CNT_W'(1);
   assign count_m2 = count - sme_pkg::CNT_W'(2);

   always_comb begin
      outcome             = '0;
      outcome.status      = sme_pkg::STAT_OK;
      outcome.count       = count;
      outcome.wr_addr     = count[sme_pkg::ADDR_W-1:0];
      outcome.wr_data     = immediate;
      if (stopped) begin
         outcome.status = sme_pkg::STAT_IGNORED;
      end else begin
         unique case (cmd)
            sme_pkg::CMD_HALT: begin
               outcome.status = sme_pkg::STAT_HALTED;
            end
            sme_pkg::CMD_PUSH: begin
               if (sme_pkg::CMP_W'(count) >= limit) begin
                  outcome.status = sme_pkg::STAT_OVERFLOW;
               end else begin
                  outcome.wr_en = 1'b1;
                  outcome.count = count + sme_pkg::CNT_W'(1);
               end
            end
            sme_pkg::CMD_POP: begin
               if (count == '0) outcome.status = sme_pkg::STAT_UNDERFLOW;
               else             outcome.count  = count_m1;
            end
            sme_pkg::CMD_ADD, sme_pkg::CMD_SUB, sme_pkg::CMD_MUL: begin
               if (count < sme_pkg::CNT_W'(2)) begin
                  outcome.status = sme_pkg::STAT_UNDERFLOW;
               end else begin
                  outcome.wr_en   = 1'b1;
                  outcome.wr_addr = count_m2[sme_pkg::ADDR_W-1:0];
                  outcome.count   = count_m1;
                  unique case (cmd)
                     sme_pkg::CMD_ADD: outcome.wr_data = sum;
                     sme_pkg::CMD_SUB: outcome.wr_data = diff;
                     default:          outcome.wr_data = prod;
                  endcase
               end
            end
            sme_pkg::CMD_SHOW: begin
               if (count == '0) begin
                  outcome.status = sme_pkg::STAT_UNDERFLOW;
               end else begin
                  outcome.shown_valid = 1'b1;
                  outcome.shown_value = op_top;
               end
            end
            sme_pkg::CMD_UNKNOWN: begin
               outcome.status = sme_pkg::STAT_UNKNOWN;
            end
         endcase
      end
      outcome.stop = !stopped && (outcome.status != sme_pkg::STAT_OK);
   end

endmodule
`default_nettype wire

/* src/stack_machine_executor.sv */
// Top level of the stack machine executor: handshakes, stack memory, sequencer.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+--------------------------------------------
//   req     | in  | req_tvalid/req_tready  | tuser: cmd; tdata: immediate
//   rsp     | out | rsp_tvalid/rsp_tready  | tuser: status; tdata: shown_valid,
//           |     |                        |   shown_value, depth
//   csr     | in  | csr_wr_en              | csr_wr_data: stack_limit
//
// Each instruction completes before the next is taken: the transfer edge issues both stack reads
// (top and next below) to the synchronous memory, the next cycle evaluates,
// writes back at most one entry and loads the result register. Since the write
// lands before the next read is issued, no forwarding is needed.
// Reset (synchronous, active high) clears the count, the stop flag, the
// sequencer and the result register and sets the limit to 256; the memory is
// not cleared, only entries below the count are ever used.
// A new request is taken only while the result register is empty or drains
// in the same cycle; a stalled rsp side therefore holds off the req side.
`default_nettype none
module stack_machine_executor (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] immediate
   input  wire logic [2:0]  req_tuser,   // [2:0] cmd
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [0] shown_valid, [32:1] shown_value,
                                         // [41:33] depth, [47:42] zero
   output logic [2:0]       rsp_tuser,   // [2:0] status
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [8:0]  csr_wr_data  // stack_limit
);

   localparam int ADDR_W  = sme_pkg::ADDR_W;
   localparam int CNT_W   = sme_pkg::CNT_W;
   localparam int DATA_W  = sme_pkg::DATA_W;
   localparam int CMP_W   = sme_pkg::CMP_W;
   localparam int DEPTH_W = sme_pkg::DEPTH_W;

   // stack storage, one write port and two registered read ports
   logic [DATA_W-1:0] stack_mem [sme_pkg::STACK_DEPTH];
   logic [DATA_W-1:0] rd_top_ff;
   logic [DATA_W-1:0] rd_next_ff;

   sme_pkg::fsm_type  state_ff, state_in;

   logic [CNT_W-1:0]             count_ff, count_in;
   logic                         stopped_ff, stopped_in;
   logic [sme_pkg::LIMIT_W-1:0]  limit_ff;
   sme_pkg::cmd_type             cmd_ff;
   logic [DATA_W-1:0]            imm_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [2:0]                   rsp_status_ff;
   logic                         rsp_shown_valid_ff;
   logic [DATA_W-1:0]            rsp_shown_value_ff;
   logic [DEPTH_W-1:0]           rsp_depth_ff;

   logic                  req_xfer;
   logic                  rsp_xfer;
   logic                  exec_now;
   logic                  slot_free;
   logic [CNT_W-1:0]      count_m1;
   logic [CNT_W-1:0]      count_m2;
   logic [CMP_W-1:0]      limit_eff;
   logic [CMP_W-1:0]      limit_wide;
   logic [CMP_W-1:0]      depth_wide;
   sme_pkg::outcome_type  outcome;

   assign req_xfer  = req_tvalid && req_tready;
   assign rsp_xfer  = rsp_valid_ff && rsp_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign count_m1  = count_ff - CNT_W'(1);
   assign count_m2  = count_ff - CNT_W'(2);

   // a limit above the stack size acts as the stack size
   assign limit_wide = CMP_W'(limit_ff);
   assign limit_eff  = (limit_wide > CMP_W'(sme_pkg::STACK_DEPTH))
                     ? CMP_W'(sme_pkg::STACK_DEPTH) : limit_wide;

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sme_pkg::FSM_IDLE: if (req_xfer) state_in = sme_pkg::FSM_EXEC;
         sme_pkg::FSM_EXEC: state_in = sme_pkg::FSM_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_tready = 1'b0;
      exec_now   = 1'b0;
      unique case (state_ff)
         sme_pkg::FSM_IDLE: req_tready = slot_free;
         sme_pkg::FSM_EXEC: exec_now   = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= sme_pkg::FSM_IDLE;
      else       state_ff <= state_in;
   end

   // capture the instruction on the request transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff <= sme_pkg::cmd_type'(req_tuser);
         imm_ff <= req_tdata;
      end
   end

   // stack memory: reads issued on transfer, write-back in the execute cycle
   always_ff @(posedge clock) begin
      if (exec_now && outcome.wr_en) stack_mem[outcome.wr_addr] <= outcome.wr_data;
      if (req_xfer) begin
         rd_top_ff  <= stack_mem[count_m1[ADDR_W-1:0]];
         rd_next_ff <= stack_mem[count_m2[ADDR_W-1:0]];
      end
   end

   sme_exec u_exec (
      .cmd       (cmd_ff),
      .immediate (imm_ff),
      .count     (count_ff),
      .stopped   (stopped_ff),
      .limit     (limit_eff),
      .op_top    (rd_top_ff),
      .op_next   (rd_next_ff),
      .outcome   (outcome)
   );

   assign count_in   = exec_now ? outcome.count : count_ff;
   assign stopped_in = stopped_ff || (exec_now && outcome.stop);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         stopped_ff <= 1'b0;
         limit_ff   <= sme_pkg::LIMIT_RESET;
      end else begin
         count_ff   <= count_in;
         stopped_ff <= stopped_in;
         if (csr_wr_en) limit_ff <= csr_wr_data;
      end
   end

   // result register
   assign depth_wide = CMP_W'(outcome.count);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_xfer) rsp_valid_in = 1'b0;
      if (exec_now) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (exec_now) begin
         rsp_status_ff      <= outcome.status;
         rsp_shown_valid_ff <= outcome.shown_valid;
         rsp_shown_value_ff <= outcome.shown_value;
         rsp_depth_ff       <= depth_wide[DEPTH_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {6'd0, rsp_depth_ff, rsp_shown_value_ff, rsp_shown_valid_ff};

endmodule
`default_nettype wire
